>>> hdl/assert_macros.svh
// Assertion helpers, clocked on clk and disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an expression holds at every clock edge.
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check that a consequent holds whenever an antecedent holds.
`define ASSERT_IMPLY(label, ante, cons, msg) \
  `ASSERT_ALWAYS(label, !(ante) || (cons), msg)

`endif

>>> hdl/nsc_pkg.sv
package nsc_pkg;

  localparam int MAX_SENTENCE_LEN_DEF = 128;
  localparam int MAX_FIELDS_DEF       = 32;
  localparam int MAX_FIELD_LEN_DEF    = 16;

  // token position register; all ones marks a dropped field or tail
  localparam int            TPOS_W   = 5;
  localparam logic [TPOS_W-1:0] POS_DROP = '1;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_COMMA = 8'h2C;

  localparam logic KIND_CHAR   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_MISMATCH  = 3'd1;
  localparam logic [2:0] ST_NO_DIGITS = 3'd2;
  localparam logic [2:0] ST_EMPTY     = 3'd3;
  localparam logic [2:0] ST_TOO_LONG  = 3'd4;
  localparam logic [2:0] ST_TRUNCATED = 3'd5;
  localparam logic [2:0] ST_FIELD_OVF = 3'd6;

  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_string;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  char_out;
    logic [4:0]  field_number;
    logic [3:0]  char_position;
    logic [7:0]  computed_sum;
    logic [15:0] received_sum;
    logic [5:0]  fields_found;
    logic [2:0]  status;
  } out_item_t;

  // classified character passed from front to back
  typedef struct packed {
    logic [7:0] chr;
    logic       eos;
    logic       nul;
    logic       is_dollar;
    logic       is_star;
    logic       is_comma;
    logic       hex_ok;
    logic [3:0] nibble;
  } cls_item_t;

endpackage

>>> hdl/nsc_front.sv
module nsc_front (
  input  nsc_pkg::in_item_t  item,
  output nsc_pkg::cls_item_t cls
);

  logic [7:0] c;
  assign c = item.char_in;

  always_comb begin
    cls           = '0;
    cls.chr       = c;
    cls.eos       = item.end_of_string;
    cls.nul       = (c == nsc_pkg::CH_NUL);
    cls.is_dollar = (c == nsc_pkg::CH_DOLLAR);
    cls.is_star   = (c == nsc_pkg::CH_STAR);
    cls.is_comma  = (c == nsc_pkg::CH_COMMA);
    if (c >= 8'h30 && c <= 8'h39) begin
      cls.hex_ok = 1'b1;
      cls.nibble = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      cls.hex_ok = 1'b1;
      cls.nibble = c[3:0] + 4'd9;
    end
  end

endmodule

>>> hdl/nsc_queue.sv
module nsc_queue #(
  parameter int DEPTH = nsc_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  nsc_pkg::cls_item_t push_data,
  output logic               full,
  input  logic               pop,
  output logic               not_empty,
  output nsc_pkg::cls_item_t pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  nsc_pkg::cls_item_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_data  = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> hdl/nsc_back.sv
module nsc_back #(
  parameter int MAX_SENTENCE_LEN = nsc_pkg::MAX_SENTENCE_LEN_DEF,
  parameter int MAX_FIELDS       = nsc_pkg::MAX_FIELDS_DEF,
  parameter int MAX_FIELD_LEN    = nsc_pkg::MAX_FIELD_LEN_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  nsc_pkg::cls_item_t q_data,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output nsc_pkg::out_item_t out_data
);

  localparam int LEN_W = $clog2(MAX_SENTENCE_LEN + 1);
  localparam int TW    = nsc_pkg::TPOS_W;

  localparam logic [1:0] PH_HUNT = 2'd0;
  localparam logic [1:0] PH_BODY = 2'd1;
  localparam logic [1:0] PH_HEX  = 2'd2;

  logic [1:0]       phase_r, phase_nxt;
  logic [7:0]       xor_r, xor_nxt;
  logic [15:0]      hex_r, hex_nxt;
  logic             seen_r, seen_nxt;
  logic [LEN_W-1:0] blen_r, blen_nxt;
  logic [5:0]       ftot_r, ftot_nxt;
  logic             intok_r, intok_nxt;
  logic [TW-1:0]    tpos_r, tpos_nxt;
  logic             ovf_r, ovf_nxt;

  logic               out_valid_r, out_valid_nxt;
  nsc_pkg::out_item_t out_data_r, out_data_nxt;

  logic               produce;
  nsc_pkg::out_item_t res;

  assign q_pop     = q_valid && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    logic       close_s;
    logic       trunc;
    logic       emit;
    logic [TW-1:0] tpos_cur;
    logic [2:0] st;

    phase_nxt = phase_r;
    xor_nxt   = xor_r;
    hex_nxt   = hex_r;
    seen_nxt  = seen_r;
    blen_nxt  = blen_r;
    ftot_nxt  = ftot_r;
    intok_nxt = intok_r;
    tpos_nxt  = tpos_r;
    ovf_nxt   = ovf_r;
    close_s   = 1'b0;
    trunc     = 1'b0;
    emit      = 1'b0;
    tpos_cur  = tpos_r;

    case (phase_r)
      PH_HUNT: begin
        if (!q_data.nul && q_data.is_dollar) begin
          xor_nxt   = '0;
          hex_nxt   = '0;
          seen_nxt  = 1'b0;
          blen_nxt  = '0;
          ftot_nxt  = '0;
          intok_nxt = 1'b0;
          tpos_nxt  = '0;
          ovf_nxt   = 1'b0;
          phase_nxt = PH_BODY;
          if (q_data.eos) begin
            close_s = 1'b1;
            trunc   = 1'b1;
          end
        end
      end
      PH_BODY: begin
        if (q_data.nul) begin
          close_s = 1'b1;
          trunc   = 1'b1;
        end else if (q_data.is_star) begin
          phase_nxt = PH_HEX;
          hex_nxt   = '0;
          seen_nxt  = 1'b0;
          close_s   = q_data.eos;
        end else begin
          if (blen_r >= LEN_W'(MAX_SENTENCE_LEN - 1)) begin
            blen_nxt = LEN_W'(MAX_SENTENCE_LEN);
          end else begin
            blen_nxt = blen_r + 1'b1;
            xor_nxt  = xor_r ^ q_data.chr;
            if (q_data.is_comma) begin
              intok_nxt = 1'b0;
            end else begin
              if (!intok_r) begin
                intok_nxt = 1'b1;
                if (ftot_r >= 6'(MAX_FIELDS)) begin
                  ovf_nxt  = 1'b1;
                  tpos_cur = nsc_pkg::POS_DROP;
                end else begin
                  ftot_nxt = ftot_r + 1'b1;
                  tpos_cur = '0;
                end
              end
              tpos_nxt = tpos_cur;
              if (tpos_cur < TW'(MAX_FIELD_LEN - 1)) begin
                emit     = 1'b1;
                tpos_nxt = tpos_cur + 1'b1;
              end else begin
                ovf_nxt  = 1'b1;
                tpos_nxt = nsc_pkg::POS_DROP;
              end
            end
          end
          if (q_data.eos) begin
            close_s = 1'b1;
            trunc   = 1'b1;
          end
        end
      end
      default: begin
        // hex digits after the star; the spare phase code behaves alike
        if (q_data.nul || !q_data.hex_ok) begin
          close_s = 1'b1;
        end else begin
          hex_nxt  = {hex_r[11:0], q_data.nibble};
          seen_nxt = 1'b1;
          close_s  = q_data.eos;
        end
      end
    endcase

    if (trunc) begin
      st = nsc_pkg::ST_TRUNCATED;
    end else if (blen_nxt == '0) begin
      st = nsc_pkg::ST_EMPTY;
    end else if (blen_nxt >= LEN_W'(MAX_SENTENCE_LEN)) begin
      st = nsc_pkg::ST_TOO_LONG;
    end else if (ovf_nxt) begin
      st = nsc_pkg::ST_FIELD_OVF;
    end else if (!seen_nxt) begin
      st = nsc_pkg::ST_NO_DIGITS;
    end else if (hex_nxt != {8'h00, xor_nxt}) begin
      st = nsc_pkg::ST_MISMATCH;
    end else begin
      st = nsc_pkg::ST_OK;
    end

    res              = '0;
    res.computed_sum = xor_nxt;
    res.fields_found = ftot_nxt;
    if (close_s) begin
      phase_nxt        = PH_HUNT;
      res.kind         = nsc_pkg::KIND_STATUS;
      res.received_sum = hex_nxt;
      res.status       = st;
    end else begin
      res.kind          = nsc_pkg::KIND_CHAR;
      res.char_out      = q_data.chr;
      res.field_number  = 5'(ftot_nxt - 6'd1);
      res.char_position = tpos_cur[3:0];
    end
    produce = close_s || emit;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (q_pop) begin
      out_valid_nxt = produce;
      out_data_nxt  = res;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HUNT;
      xor_r       <= '0;
      hex_r       <= '0;
      seen_r      <= 1'b0;
      blen_r      <= '0;
      ftot_r      <= '0;
      intok_r     <= 1'b0;
      tpos_r      <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        phase_r <= phase_nxt;
        xor_r   <= xor_nxt;
        hex_r   <= hex_nxt;
        seen_r  <= seen_nxt;
        blen_r  <= blen_nxt;
        ftot_r  <= ftot_nxt;
        intok_r <= intok_nxt;
        tpos_r  <= tpos_nxt;
        ovf_r   <= ovf_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

endmodule

>>> hdl/nmea_sentence_checker_top.sv
// Channel   Direction  Handshake              Payload
// in_       input      in_valid / in_ready    nsc_pkg::in_item_t  (one character)
// out_      output     out_valid / out_ready  nsc_pkg::out_item_t (field char or status)
//
// One character is taken every cycle while the queue has room; each result passes
// through the queue and then the output register before it leaves.
// Reset is synchronous on rst_n low and returns the parser to hunting for '$'.
// A stalled output holds the back end; the two-entry queue keeps in_ready high
// until it fills, so the input side stalls only after two items back up.
`include "assert_macros.svh"

module nmea_sentence_checker_top #(
  parameter int MAX_SENTENCE_LEN = nsc_pkg::MAX_SENTENCE_LEN_DEF,
  parameter int MAX_FIELDS       = nsc_pkg::MAX_FIELDS_DEF,
  parameter int MAX_FIELD_LEN    = nsc_pkg::MAX_FIELD_LEN_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  nsc_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output nsc_pkg::out_item_t out_data
);

  nsc_pkg::cls_item_t cls;      // classified character from the front end
  nsc_pkg::cls_item_t q_data;   // head of the queue
  logic               q_full;
  logic               q_valid;
  logic               q_pop;
  logic               push;

  // Front end: classify the character as it arrives.
  nsc_front u_front (
    .item (in_data),
    .cls  (cls)
  );

  // Accept whenever the queue has room; nothing else holds the input.
  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  nsc_queue #(
    .DEPTH (nsc_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (cls),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_data  (q_data)
  );

  // Back end: run the sentence state and hold each result in the output register.
  nsc_back #(
    .MAX_SENTENCE_LEN (MAX_SENTENCE_LEN),
    .MAX_FIELDS       (MAX_FIELDS),
    .MAX_FIELD_LEN    (MAX_FIELD_LEN)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // An ok status means the received value equals the computed XOR.
  `ASSERT_IMPLY(a_ok_matches, out_valid && out_data.kind == nsc_pkg::KIND_STATUS && out_data.status == nsc_pkg::ST_OK, out_data.received_sum == {8'h00, out_data.computed_sum}, "ok status with differing sums")

  // A field character always belongs to a counted field and carries no status.
  `ASSERT_IMPLY(a_char_fields, out_valid && out_data.kind == nsc_pkg::KIND_CHAR, out_data.fields_found != 6'd0 && out_data.status == nsc_pkg::ST_OK && out_data.received_sum == 16'h0000, "field character with bad side fields")

  // The back end only pops the queue when an item is there.
  `ASSERT_IMPLY(a_pop_valid, q_pop, q_valid, "queue popped while empty")

endmodule

>>> test/nmea_result_checker.sv
`timescale 1ns / 100ps

module nmea_result_checker
  import nsc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_data,
  output int        mismatch_count,
  output int        results_owed
);

  localparam int PRINT_CAP = 100;

  typedef enum logic [1:0] {
    SEEK_DOLLAR,
    IN_BODY,
    IN_HEX
  } parse_phase_e;

  parse_phase_e phase;
  logic [7:0]   xor_sum;
  logic [15:0]  hex_sum;
  logic         digit_seen;
  int           body_len;
  int           field_cnt;
  logic         in_field;
  int           field_pos;
  logic         ovf_seen;

  out_item_t expected_results[$];
  out_item_t want;
  int        fail_tally = 0;

  initial begin
    mismatch_count = 0;
    results_owed   = 0;
  end

  task automatic report_mismatch(input string msg);
    if (fail_tally < PRINT_CAP) $display("%0t mismatch: %s", $realtime, msg);
    fail_tally++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] exp_val);
    if (got !== exp_val)
      report_mismatch($sformatf("%s got %0h want %0h", name, got, exp_val));
  endtask

  task automatic clear_sentence();
    xor_sum    = 8'h00;
    hex_sum    = 16'h0000;
    digit_seen = 1'b0;
    body_len   = 0;
    field_cnt  = 0;
    in_field   = 1'b0;
    field_pos  = 0;
    ovf_seen   = 1'b0;
  endtask

  // close the sentence with the first status that applies
  task automatic close_sentence(input logic truncated);
    out_item_t r;
    r              = '0;
    r.kind         = KIND_STATUS;
    r.computed_sum = xor_sum;
    r.received_sum = hex_sum;
    r.fields_found = field_cnt[5:0];
    if (truncated)                           r.status = ST_TRUNCATED;
    else if (body_len == 0)                  r.status = ST_EMPTY;
    else if (body_len >= MAX_SENTENCE_LEN_DEF) r.status = ST_TOO_LONG;
    else if (ovf_seen)                       r.status = ST_FIELD_OVF;
    else if (!digit_seen)                    r.status = ST_NO_DIGITS;
    else if (hex_sum != {8'h00, xor_sum})    r.status = ST_MISMATCH;
    else                                     r.status = ST_OK;
    expected_results.push_back(r);
    phase = SEEK_DOLLAR;
  endtask

  task automatic parse_char(input in_item_t it);
    logic [7:0] c;
    logic       eos;
    logic       nul;
    logic       emit;
    int         nib;
    int         fnum;
    int         pos;
    out_item_t  r;
    c    = it.char_in;
    eos  = it.end_of_string;
    nul  = (c == CH_NUL);
    emit = 1'b0;
    fnum = 0;
    pos  = 0;
    case (phase)
      SEEK_DOLLAR: begin
        if (!nul && c == CH_DOLLAR) begin
          clear_sentence();
          phase = IN_BODY;
          if (eos) close_sentence(1'b1);
        end
      end
      IN_BODY: begin
        if (nul) begin
          close_sentence(1'b1);
        end else if (c == CH_STAR) begin
          phase      = IN_HEX;
          hex_sum    = 16'h0000;
          digit_seen = 1'b0;
          if (eos) close_sentence(1'b0);
        end else begin
          if (body_len >= MAX_SENTENCE_LEN_DEF - 1) begin
            body_len = MAX_SENTENCE_LEN_DEF;
          end else begin
            body_len++;
            xor_sum ^= c;
            if (c == CH_COMMA) begin
              in_field = 1'b0;
            end else begin
              if (!in_field) begin
                in_field = 1'b1;
                if (field_cnt >= MAX_FIELDS_DEF) begin
                  ovf_seen  = 1'b1;
                  field_pos = POS_DROP;
                end else begin
                  field_cnt++;
                  field_pos = 0;
                end
              end
              if (field_pos < MAX_FIELD_LEN_DEF - 1) begin
                emit = 1'b1;
                fnum = field_cnt - 1;
                pos  = field_pos;
                field_pos++;
              end else begin
                ovf_seen  = 1'b1;
                field_pos = POS_DROP;
              end
            end
          end
          if (eos) begin
            close_sentence(1'b1);
          end else if (emit) begin
            r               = '0;
            r.kind          = KIND_CHAR;
            r.char_out      = c;
            r.field_number  = fnum[4:0];
            r.char_position = pos[3:0];
            r.computed_sum  = xor_sum;
            r.fields_found  = field_cnt[5:0];
            expected_results.push_back(r);
          end
        end
      end
      default: begin
        if (c >= "0" && c <= "9")      nib = c - "0";
        else if (c >= "a" && c <= "f") nib = c - "a" + 10;
        else if (c >= "A" && c <= "F") nib = c - "A" + 10;
        else                           nib = -1;
        if (nib < 0) begin
          close_sentence(1'b0);
        end else begin
          hex_sum    = {hex_sum[11:0], nib[3:0]};
          digit_seen = 1'b1;
          if (eos) close_sentence(1'b0);
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      expected_results.delete();
      phase = SEEK_DOLLAR;
      clear_sentence();
    end else begin
      // compare first: no result can stem from an item taken at this same edge
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected: %h", out_data));
        end else begin
          want = expected_results.pop_front();
          check_field("kind", out_data.kind, want.kind);
          check_field("char_out", out_data.char_out, want.char_out);
          check_field("field_number", out_data.field_number, want.field_number);
          check_field("char_position", out_data.char_position, want.char_position);
          check_field("computed_sum", out_data.computed_sum, want.computed_sum);
          check_field("received_sum", out_data.received_sum, want.received_sum);
          check_field("fields_found", out_data.fields_found, want.fields_found);
          check_field("status", out_data.status, want.status);
        end
      end
      if (in_valid && in_ready) parse_char(in_data);
    end
    results_owed   <= expected_results.size();
    mismatch_count <= fail_tally;
  end

endmodule

>>> test/nmea_sentence_checker_top_tb.sv
`timescale 1ns / 100ps

module nmea_sentence_checker_top_tb;
  import nsc_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 8;
  localparam int ITEM_TARGET    = 900;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  int mismatch_count;
  int results_owed;

  // idling controls: sender gaps and receiver stall bursts
  bit send_gaps   = 1'b0;
  bit sink_stalls = 1'b0;
  int counted_items = 0;
  int stall_left    = 0;
  int idle_cycles   = 0;
  bit paused_once   = 1'b0;

  always #4 clk = ~clk;

  nmea_sentence_checker_top u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // watch both channels, predict every result and compare
  nmea_result_checker u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .mismatch_count(mismatch_count),
    .results_owed  (results_owed)
  );

  // Receiver: hold out_ready low for random bursts while stalls are
  // enabled, otherwise keep it high.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 9) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog: count cycles in which neither channel moves an item.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL nmea_sentence_checker_top");
      $finish;
    end
  end

  function automatic in_item_t chr_item(input logic [7:0] c, input logic eos);
    in_item_t it;
    it.char_in       = c;
    it.end_of_string = eos;
    return it;
  endfunction

  // printable field content; a dollar sign now and then, never a star or comma
  function automatic logic [7:0] field_char();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(8'h20, 8'h7E));
    end while (c == CH_STAR || c == CH_COMMA ||
               (c == CH_DOLLAR && $urandom_range(0, 3) != 0));
    return c;
  endfunction

  // any byte but a dollar sign, so the block stays hunting
  function automatic logic [7:0] noise_char();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(0, 255));
    end while (c == CH_DOLLAR);
    return c;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 10) return 8'("0") + nib;
    return ($urandom_range(0, 1) ? 8'("a") : 8'("A")) + nib - 4'd10;
  endfunction

  // Drive one item at the rising edge, with an optional gap ahead of it, and
  // hold it until the block takes it.
  task automatic send_item(input in_item_t it, input bit counted);
    if (send_gaps && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    if (counted) counted_items++;
  endtask

  task automatic send_text(input string s, input bit eos_last);
    for (int i = 0; i < s.len(); i++)
      send_item(chr_item(s[i], eos_last && (i == s.len() - 1)), 1'b1);
  endtask

  // Build one sentence: mostly well formed with a correct checksum, sometimes
  // with a wrong or missing checksum, too many or too long fields, an overlong
  // body, or cut short by an end mark or a NUL.
  task automatic send_sentence();
    in_item_t    line[$];
    logic [7:0]  body[$];
    logic [7:0]  sum;
    logic [31:0] hv;
    in_item_t    tmp;
    int          shape;
    int          nf;
    int          flen;
    int          nd;
    int          pick;
    int          cut;
    int          target;

    // lead-in noise is ignored by the block and does not count
    repeat ($urandom_range(0, 2))
      send_item(chr_item(noise_char(), $urandom_range(0, 9) == 0), 1'b0);

    shape = $urandom_range(0, 39);
    nf    = (shape == 0) ? $urandom_range(31, 36) : $urandom_range(0, 6);
    for (int i = 0; i < nf; i++) begin
      // runs of commas collapse; a leading comma is optional
      if (i > 0 || $urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 2)) body.push_back(CH_COMMA);
      if (shape == 0)
        flen = 1;
      else if ($urandom_range(0, 9) == 0)
        flen = $urandom_range(14, 18);
      else
        flen = $urandom_range(1, 6);
      repeat (flen) body.push_back(field_char());
    end
    if ($urandom_range(0, 3) == 0) body.push_back(CH_COMMA);
    if (shape == 1) begin
      // straddle the body length limit
      target = $urandom_range(126, 135);
      while (body.size() < target)
        body.push_back(($urandom_range(0, 4) == 0) ? CH_COMMA : field_char());
    end

    sum = 8'h00;
    foreach (body[i]) sum ^= body[i];

    line.push_back(chr_item(CH_DOLLAR, 1'b0));
    foreach (body[i]) line.push_back(chr_item(body[i], 1'b0));
    line.push_back(chr_item(CH_STAR, 1'b0));

    pick = $urandom_range(0, 9);
    if (pick == 0)      nd = 0;
    else if (pick == 1) nd = $urandom_range(1, 5);
    else                nd = ($urandom_range(0, 4) == 0) ? 4 : 2;
    hv = (pick == 1) ? $urandom : {24'h0, sum};
    for (int i = nd - 1; i >= 0; i--)
      line.push_back(chr_item(hex_char(hv[4*i +: 4]), 1'b0));

    case ($urandom_range(0, 4))
      0: begin
        tmp = line.pop_back();
        tmp.end_of_string = 1'b1;
        line.push_back(tmp);
      end
      1:       line.push_back(chr_item(CH_NUL, 1'b0));
      2:       line.push_back(chr_item(8'h0D, 1'b0));
      3:       line.push_back(chr_item(CH_DOLLAR, 1'b0));
      default: line.push_back(chr_item(8'("g") + 8'($urandom_range(0, 19)), 1'b0));
    endcase

    // cut the sentence short inside the body now and then
    if ($urandom_range(0, 14) == 0) begin
      cut = $urandom_range(0, body.size());
      while (line.size() > cut + 1) void'(line.pop_back());
      if ($urandom_range(0, 1)) begin
        tmp = line.pop_back();
        tmp.end_of_string = 1'b1;
        line.push_back(tmp);
      end else begin
        line.push_back(chr_item(CH_NUL, 1'b0));
      end
    end

    foreach (line[i]) send_item(line[i], 1'b1);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    send_gaps = 1'b1;
    sink_stalls <= 1'b1;

    // Directed: end mark and NUL while hunting, a bare dollar with the end
    // mark, an empty body, a good sentence with empty fields, a mismatch with
    // mixed-case digits closed by a dollar, no digits, NUL in the body, the
    // end mark on a body character, and the all-ones byte.
    send_item(chr_item(8'h78, 1'b1), 1'b0);
    send_item(chr_item(CH_NUL, 1'b0), 1'b0);
    send_item(chr_item(8'hFF, 1'b0), 1'b0);
    send_text("$", 1'b1);
    send_text("$*", 1'b1);
    send_text("$A,,B*03\015", 1'b0);
    send_text("$AB*Ff$", 1'b0);
    send_text("$C*G", 1'b0);
    send_text("$D", 1'b0);
    send_item(chr_item(CH_NUL, 1'b0), 1'b1);
    send_text("$E", 1'b1);

    // Random sentences: idling in the first stretches, a clean stretch in the
    // middle, and none at all towards the end.
    while (counted_items < ITEM_TARGET) begin
      send_gaps = (counted_items < 250) ||
                  (counted_items >= 400 && counted_items < 750);
      sink_stalls <= send_gaps;
      if (!paused_once && counted_items >= 500) begin
        // hold the sender until every owed result has come out
        paused_once = 1'b1;
        in_valid <= 1'b0;
        do @(posedge clk); while (results_owed != 0);
      end
      send_sentence();
    end

    // drain, then let the pipeline settle before the verdict
    in_valid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS nmea_sentence_checker_top");
    end else begin
      $display("FAIL nmea_sentence_checker_top");
    end
    $finish;
  end

endmodule

>>> nmea_sentence_checker_top.f
+incdir+hdl
hdl/nsc_pkg.sv
hdl/nsc_front.sv
hdl/nsc_queue.sv
hdl/nsc_back.sv
hdl/nmea_sentence_checker_top.sv
test/nmea_result_checker.sv
test/nmea_sentence_checker_top_tb.sv
